// ----- rtl/core/fpdh_pkg.sv -----
// shared constants and types of the packet deframer with heartbeat
package fpdh_pkg;

  localparam int PAYLOAD_BYTES = 4;
  localparam int CNT_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int DATA_W        = 64;
  localparam int SIL_W         = 16;
  localparam int CFG_IDX_W     = 8;
  localparam int CFG_DATA_W    = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_PING_CODE     = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = CFG_IDX_W'(3);

  localparam logic [7:0]       SYNC_FIRST_RST  = 8'd170;
  localparam logic [7:0]       SYNC_SECOND_RST = 8'd85;
  localparam logic [7:0]       PING_CODE_RST   = 8'd80;
  localparam logic [SIL_W-1:0] TIMEOUT_RST     = SIL_W'(5);

  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [3:0] {
    PH_SYNC1 = 4'b0001,
    PH_SYNC2 = 4'b0010,
    PH_DATA  = 4'b0100,
    PH_CHECK = 4'b1000
  } phase_t;

endpackage

// ----- rtl/core/fpdh_item_if.sv -----
// input item channel: received byte or time tick
interface fpdh_item_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink (input valid, input func, input rx_byte, output ready);
endinterface

// ----- rtl/core/fpdh_result_if.sv -----
// result item channel: heartbeat events and delivered packet
interface fpdh_result_if;
  logic                        valid;
  logic                        ready;
  logic                        send_pong;
  logic                        link_up_event;
  logic                        link_lost_event;
  logic                        packet_ready;
  logic                        checksum_error;
  logic [fpdh_pkg::DATA_W-1:0] packet_data;

  modport source (output valid, output send_pong, output link_up_event,
                  output link_lost_event, output packet_ready, output checksum_error,
                  output packet_data, input ready);
  modport sink (input valid, input send_pong, input link_up_event,
                input link_lost_event, input packet_ready, input checksum_error,
                input packet_data, output ready);
endinterface

// ----- rtl/core/fpdh_cfg_if.sv -----
// configuration write channel
interface fpdh_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [fpdh_pkg::CFG_IDX_W-1:0]  index;
  logic [fpdh_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/framed_packet_deframer_heartbeat.sv -----
// top level: two-sync-byte packet deframer with xor checksum and heartbeat link watch
//
// Each input item is a received byte or a time tick and yields exactly one result item.
// An item is handled combinationally by the parser and link logic, and its result
// sits in a single result register; a new item is taken whenever that register is
// empty or its item is being taken in the same cycle, so the block sustains one item
// per cycle while the result side is ready. Configuration writes are always accepted
// and take effect at the next item.
module framed_packet_deframer_heartbeat (
  input logic            clk,
  input logic            rst,
  fpdh_item_if.sink      item,
  fpdh_result_if.source  result,
  fpdh_cfg_if.sink       cfg
);

  logic [7:0]                       sync_first;
  logic [7:0]                       sync_second;
  logic [7:0]                       ping_code;
  logic [fpdh_pkg::SIL_W-1:0]       timeout_ticks;

  fpdh_pkg::phase_t                 phase, phase_next;
  logic [7:0]                       store [fpdh_pkg::PAYLOAD_BYTES];
  logic [7:0]                       store_next [fpdh_pkg::PAYLOAD_BYTES];
  logic [fpdh_pkg::CNT_W-1:0]       cnt, cnt_next;
  logic [7:0]                       xsum, xsum_next;
  logic                             link_alive, link_alive_next;
  logic [fpdh_pkg::SIL_W-1:0]       silence, silence_next;

  logic                             pong, up_ev, lost_ev, ready_ev, err_ev;
  logic [fpdh_pkg::DATA_W-1:0]      data_c;
  logic                             accept;

  assign cfg.ready  = 1'b1;
  assign item.ready = !result.valid || result.ready;
  assign accept     = item.valid && item.ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first    <= fpdh_pkg::SYNC_FIRST_RST;
      sync_second   <= fpdh_pkg::SYNC_SECOND_RST;
      ping_code     <= fpdh_pkg::PING_CODE_RST;
      timeout_ticks <= fpdh_pkg::TIMEOUT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        fpdh_pkg::REG_SYNC_FIRST:    sync_first    <= cfg.data[7:0];
        fpdh_pkg::REG_SYNC_SECOND:   sync_second   <= cfg.data[7:0];
        fpdh_pkg::REG_PING_CODE:     ping_code     <= cfg.data[7:0];
        fpdh_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg.data[fpdh_pkg::SIL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_next      = phase;
    store_next      = store;
    cnt_next        = cnt;
    xsum_next       = xsum;
    link_alive_next = link_alive;
    silence_next    = silence;
    pong            = 1'b0;
    up_ev           = 1'b0;
    lost_ev         = 1'b0;
    ready_ev        = 1'b0;
    err_ev          = 1'b0;
    data_c          = '0;

    if (item.func == fpdh_pkg::FUNC_TICK) begin
      if (silence != {fpdh_pkg::SIL_W{1'b1}}) begin
        silence_next = silence + fpdh_pkg::SIL_W'(1);
      end
      if (link_alive && (silence_next > timeout_ticks)) begin
        link_alive_next = 1'b0;
        lost_ev         = 1'b1;
      end
    end else if (item.rx_byte == ping_code) begin
      pong            = 1'b1;
      up_ev           = !link_alive;
      link_alive_next = 1'b1;
      silence_next    = '0;
      phase_next      = fpdh_pkg::PH_SYNC1;
      cnt_next        = '0;
      xsum_next       = '0;
      for (int i = 0; i < fpdh_pkg::PAYLOAD_BYTES; i++) store_next[i] = '0;
    end else begin
      case (phase)
        fpdh_pkg::PH_SYNC1: begin
          if (item.rx_byte == sync_first) phase_next = fpdh_pkg::PH_SYNC2;
        end
        fpdh_pkg::PH_SYNC2: begin
          if (item.rx_byte == sync_second) begin
            phase_next = fpdh_pkg::PH_DATA;
            cnt_next   = '0;
            xsum_next  = '0;
            for (int i = 0; i < fpdh_pkg::PAYLOAD_BYTES; i++) store_next[i] = '0;
          end else if (item.rx_byte != sync_first) begin
            phase_next = fpdh_pkg::PH_SYNC1;
          end
        end
        fpdh_pkg::PH_DATA: begin
          for (int i = 0; i < fpdh_pkg::PAYLOAD_BYTES; i++) begin
            if (cnt == fpdh_pkg::CNT_W'(i)) store_next[i] = item.rx_byte;
          end
          xsum_next = xsum ^ item.rx_byte;
          cnt_next  = cnt + fpdh_pkg::CNT_W'(1);
          if (cnt_next == fpdh_pkg::CNT_W'(fpdh_pkg::PAYLOAD_BYTES)) begin
            phase_next = fpdh_pkg::PH_CHECK;
          end
        end
        default: begin
          if (item.rx_byte == xsum) begin
            if (link_alive) begin
              ready_ev = 1'b1;
              for (int i = 0; i < fpdh_pkg::PAYLOAD_BYTES; i++) data_c[8*i +: 8] = store[i];
            end
          end else begin
            err_ev = 1'b1;
          end
          phase_next = fpdh_pkg::PH_SYNC1;
          cnt_next   = '0;
          xsum_next  = '0;
          for (int i = 0; i < fpdh_pkg::PAYLOAD_BYTES; i++) store_next[i] = '0;
        end
      endcase
    end
  end

  // parser and link state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= fpdh_pkg::PH_SYNC1;
      cnt        <= '0;
      xsum       <= '0;
      link_alive <= 1'b0;
      silence    <= '0;
      for (int i = 0; i < fpdh_pkg::PAYLOAD_BYTES; i++) store[i] <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      cnt        <= cnt_next;
      xsum       <= xsum_next;
      link_alive <= link_alive_next;
      silence    <= silence_next;
      store      <= store_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (accept) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.send_pong       <= pong;
      result.link_up_event   <= up_ev;
      result.link_lost_event <= lost_ev;
      result.packet_ready    <= ready_ev;
      result.checksum_error  <= err_ev;
      result.packet_data     <= data_c;
    end
  end

  a_up_needs_pong: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.link_up_event |-> result.send_pong)
    else $error("link up event without pong");

  a_data_only_when_ready: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.packet_ready |-> result.packet_data == '0)
    else $error("packet data without packet");

  a_ready_err_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.packet_ready && result.checksum_error))
    else $error("packet both good and bad");

  a_ping_brings_link_up: assert property (@(posedge clk) disable iff (rst)
    accept && item.func == fpdh_pkg::FUNC_BYTE && item.rx_byte == ping_code
    |=> link_alive && silence == '0 && phase == fpdh_pkg::PH_SYNC1)
    else $error("ping did not restore link state");

  a_lost_needs_alive: assert property (@(posedge clk) disable iff (rst)
    accept && lost_ev |-> link_alive && item.func == fpdh_pkg::FUNC_TICK)
    else $error("link lost without live link");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// testbench of the packet deframer with heartbeat: directed table, random traffic, predictor
module testbench;
  import fpdh_pkg::*;

  typedef struct packed {
    logic              pong;
    logic              link_up;
    logic              link_lost;
    logic              pkt_ready;
    logic              ck_err;
    logic [DATA_W-1:0] data;
  } deframe_out_t;

  typedef struct packed {
    logic         func;
    logic [7:0]   rx_byte;
    logic         typed;
    deframe_out_t want;
  } script_row_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_LAST  = '1;

  localparam deframe_out_t OUT_NONE    = '0;
  localparam deframe_out_t OUT_PONG_UP = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 64'd0};
  localparam deframe_out_t OUT_PONG    = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 64'd0};
  localparam deframe_out_t OUT_LOST    = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 64'd0};
  localparam deframe_out_t OUT_CK_ERR  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 64'd0};

  localparam script_row_t OPENING [26] = '{
    '{FUNC_TICK, 8'h00, 1'b1, OUT_NONE},
    '{FUNC_BYTE, SYNC_FIRST_RST, 1'b0, OUT_NONE},
    '{FUNC_BYTE, SYNC_SECOND_RST, 1'b0, OUT_NONE},
    '{FUNC_BYTE, 8'h01, 1'b0, OUT_NONE},
    '{FUNC_BYTE, 8'h02, 1'b0, OUT_NONE},
    '{FUNC_BYTE, 8'h03, 1'b0, OUT_NONE},
    '{FUNC_BYTE, 8'h04, 1'b0, OUT_NONE},
    '{FUNC_BYTE, 8'h55, 1'b1, OUT_CK_ERR},
    '{FUNC_BYTE, PING_CODE_RST, 1'b1, OUT_PONG_UP},
    '{FUNC_BYTE, SYNC_FIRST_RST, 1'b0, OUT_NONE},
    '{FUNC_BYTE, SYNC_FIRST_RST, 1'b0, OUT_NONE},
    '{FUNC_BYTE, SYNC_SECOND_RST, 1'b0, OUT_NONE},
    '{FUNC_BYTE, 8'h00, 1'b0, OUT_NONE},
    '{FUNC_BYTE, 8'hFF, 1'b0, OUT_NONE},
    '{FUNC_BYTE, 8'h01, 1'b0, OUT_NONE},
    '{FUNC_BYTE, 8'h80, 1'b0, OUT_NONE},
    '{FUNC_BYTE, 8'h7E, 1'b0, OUT_NONE},
    '{FUNC_BYTE, SYNC_FIRST_RST, 1'b0, OUT_NONE},
    '{FUNC_BYTE, SYNC_SECOND_RST, 1'b0, OUT_NONE},
    '{FUNC_BYTE, PING_CODE_RST, 1'b1, OUT_PONG},
    '{FUNC_TICK, 8'hFF, 1'b0, OUT_NONE},
    '{FUNC_TICK, 8'h00, 1'b0, OUT_NONE},
    '{FUNC_TICK, 8'hFF, 1'b0, OUT_NONE},
    '{FUNC_TICK, 8'h00, 1'b0, OUT_NONE},
    '{FUNC_TICK, 8'hFF, 1'b0, OUT_NONE},
    '{FUNC_TICK, 8'h00, 1'b1, OUT_LOST}
  };

  logic clk;
  logic rst;

  fpdh_item_if   item_ch ();
  fpdh_result_if res_ch ();
  fpdh_cfg_if    cfg_ch ();

  framed_packet_deframer_heartbeat i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  // predictor state
  logic [7:0]        cur_sync1;
  logic [7:0]        cur_sync2;
  logic [7:0]        cur_ping;
  logic [SIL_W-1:0]  cur_timeout;
  phase_t            phase;
  logic [DATA_W-1:0] pay_acc;
  int                pay_cnt;
  logic [7:0]        pay_xor;
  logic              link_on;
  logic [SIL_W-1:0]  quiet_ticks;

  // stimulus side
  logic [7:0]   set_s1;
  logic [7:0]   set_s2;
  logic [7:0]   set_ping;
  logic         item_typed;
  deframe_out_t item_want;
  bit           idle_en;
  int           stall_left;
  int           fed;
  int           results_seen;
  int           delivered;
  int           bad_sums;
  int           drops;
  int           errors;

  deframe_out_t due_q [$];

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (!idle_en || p < 60) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void drop_payload();
    pay_acc = '0;
    pay_cnt = 0;
    pay_xor = '0;
  endfunction

  function automatic deframe_out_t deframe_step(input logic f, input logic [7:0] b);
    deframe_out_t o;
    o = '0;
    if (f == FUNC_TICK) begin
      if (quiet_ticks != '1) quiet_ticks++;
      if (link_on && quiet_ticks > cur_timeout) begin
        link_on     = 1'b0;
        o.link_lost = 1'b1;
      end
    end else if (b == cur_ping) begin
      o.pong      = 1'b1;
      o.link_up   = !link_on;
      link_on     = 1'b1;
      quiet_ticks = '0;
      phase       = PH_SYNC1;
      drop_payload();
    end else begin
      case (phase)
        PH_SYNC1: begin
          if (b == cur_sync1) phase = PH_SYNC2;
        end
        PH_SYNC2: begin
          if (b == cur_sync2) begin
            phase = PH_DATA;
            drop_payload();
          end else if (b != cur_sync1) begin
            phase = PH_SYNC1;
          end
        end
        PH_DATA: begin
          pay_acc[8*pay_cnt +: 8] = b;
          pay_xor ^= b;
          pay_cnt++;
          if (pay_cnt >= PAYLOAD_BYTES) phase = PH_CHECK;
        end
        default: begin
          if (b == pay_xor) begin
            if (link_on) begin
              o.pkt_ready = 1'b1;
              o.data      = pay_acc;
            end
          end else begin
            o.ck_err = 1'b1;
          end
          phase = PH_SYNC1;
          drop_payload();
        end
      endcase
    end
    return o;
  endfunction

  always @(posedge clk) begin
    deframe_out_t want;
    deframe_out_t got;
    if (rst) begin
      cur_sync1   = SYNC_FIRST_RST;
      cur_sync2   = SYNC_SECOND_RST;
      cur_ping    = PING_CODE_RST;
      cur_timeout = TIMEOUT_RST;
      phase       = PH_SYNC1;
      link_on     = 1'b0;
      quiet_ticks = '0;
      drop_payload();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_SYNC_FIRST:    cur_sync1   = cfg_ch.data[7:0];
          REG_SYNC_SECOND:   cur_sync2   = cfg_ch.data[7:0];
          REG_PING_CODE:     cur_ping    = cfg_ch.data[7:0];
          REG_TIMEOUT_TICKS: cur_timeout = cfg_ch.data[SIL_W-1:0];
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        want = deframe_step(item_ch.func, item_ch.rx_byte);
        if (item_typed) want = item_want;
        due_q.insert(due_q.size(), want);
      end
      if (res_ch.valid && res_ch.ready) begin
        got = '{res_ch.send_pong, res_ch.link_up_event, res_ch.link_lost_event,
                res_ch.packet_ready, res_ch.checksum_error, res_ch.packet_data};
        results_seen++;
        if (got.pkt_ready) delivered++;
        if (got.ck_err) bad_sums++;
        if (got.link_lost) drops++;
        if (due_q.size() == 0) begin
          if (errors < 10) $display("unexpected result item at %0t", $realtime);
          errors++;
        end else begin
          want = due_q.pop_front();
          if (got.pong != want.pong || got.link_up != want.link_up ||
              got.link_lost != want.link_lost || got.pkt_ready != want.pkt_ready ||
              got.ck_err != want.ck_err || got.data != want.data) begin
            if (errors < 10) begin
              $display("mismatch at %0t: pong %b/%b up %b/%b lost %b/%b ready %b/%b err %b/%b",
                       $realtime, want.pong, got.pong, want.link_up, got.link_up,
                       want.link_lost, got.link_lost, want.pkt_ready, got.pkt_ready,
                       want.ck_err, got.ck_err);
              $display("  data expected %h got %h", want.data, got.data);
            end
            errors++;
          end
        end
      end
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (idle_en && $urandom_range(0, 99) < 25) stall_left = pick_gap();
    end
  end

  task automatic send_item(input logic f, input logic [7:0] b, input logic typed,
                           input deframe_out_t want);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid   <= 1'b1;
    item_ch.func    <= f;
    item_ch.rx_byte <= b;
    item_typed      <= typed;
    item_want       <= want;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    fed++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] s1, input logic [7:0] s2,
                               input logic [7:0] ping, input logic [SIL_W-1:0] tmo);
    item_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_q.size() != 0) @(posedge clk);
    write_reg(REG_SYNC_FIRST, {8'($urandom), s1});
    write_reg(REG_SYNC_SECOND, {8'($urandom), s2});
    write_reg(REG_PING_CODE, {8'($urandom), ping});
    write_reg(REG_TIMEOUT_TICKS, tmo);
    write_reg($urandom_range(0, 1) ? REG_SPARE : REG_LAST, 16'($urandom));
    cfg_ch.valid <= 1'b0;
    set_s1   = s1;
    set_s2   = s2;
    set_ping = ping;
    idle_en  = 1'b1;
  endtask

  task automatic random_traffic(input int n);
    int goal;
    int pick;
    int k;
    int cut;
    logic [7:0] b;
    logic [7:0] sum;
    goal = fed + n;
    while (fed < goal) begin
      if ($urandom_range(0, 9) == 0) idle_en = !idle_en;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        send_item(FUNC_BYTE, set_ping, 1'b0, OUT_NONE);
      end else if (pick < 27) begin
        k = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 3);
        repeat (k) send_item(FUNC_TICK, 8'($urandom), 1'b0, OUT_NONE);
      end else if (pick < 37) begin
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0: b = set_s1;
            1: b = set_s2;
            default: b = 8'($urandom);
          endcase
          send_item(FUNC_BYTE, b, 1'b0, OUT_NONE);
        end
      end else begin
        send_item(FUNC_BYTE, set_s1, 1'b0, OUT_NONE);
        if ($urandom_range(0, 4) == 0) send_item(FUNC_BYTE, set_s1, 1'b0, OUT_NONE);
        send_item(FUNC_BYTE, set_s2, 1'b0, OUT_NONE);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, PAYLOAD_BYTES - 1)
                                          : PAYLOAD_BYTES;
        sum = '0;
        for (int i = 0; i < cut; i++) begin
          case ($urandom_range(0, 7))
            0: b = 8'h00;
            1: b = 8'hFF;
            default: b = 8'($urandom);
          endcase
          sum ^= b;
          send_item(FUNC_BYTE, b, 1'b0, OUT_NONE);
        end
        if (cut < PAYLOAD_BYTES) begin
          if ($urandom_range(0, 1) == 0) send_item(FUNC_BYTE, set_ping, 1'b0, OUT_NONE);
        end else if ($urandom_range(0, 3) == 0) begin
          send_item(FUNC_BYTE, sum ^ 8'($urandom_range(1, 255)), 1'b0, OUT_NONE);
        end else begin
          send_item(FUNC_BYTE, sum, 1'b0, OUT_NONE);
        end
      end
    end
  endtask

  initial begin
    int waited;
    rst             = 1'b1;
    item_ch.valid   = 1'b0;
    item_ch.func    = FUNC_BYTE;
    item_ch.rx_byte = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = '0;
    res_ch.ready    = 1'b0;
    item_typed      = 1'b0;
    item_want       = OUT_NONE;
    set_s1          = SYNC_FIRST_RST;
    set_s2          = SYNC_SECOND_RST;
    set_ping        = PING_CODE_RST;
    idle_en         = 1'b1;
    stall_left      = 0;
    fed             = 0;
    results_seen    = 0;
    delivered       = 0;
    bad_sums        = 0;
    drops           = 0;
    errors          = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (OPENING[i])
      send_item(OPENING[i].func, OPENING[i].rx_byte, OPENING[i].typed, OPENING[i].want);
    random_traffic(200);

    apply_setting(8'h00, 8'hFF, 8'h7E, 16'd0);
    random_traffic(200);
    apply_setting(8'hFF, 8'h00, 8'h01, 16'hFFFF);
    random_traffic(200);
    // equal sync bytes
    apply_setting(8'h3C, 8'h3C, 8'hC3, 16'd3);
    random_traffic(200);
    // ping shadows a sync byte
    apply_setting(8'h50, 8'hA5, 8'h50, 16'd10);
    random_traffic(200);
    apply_setting(8'h11, 8'h22, 8'h22, 16'd7);
    random_traffic(200);
    repeat (2) begin
      apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom_range(0, 20)));
      random_traffic(100);
    end

    item_ch.valid <= 1'b0;
    @(posedge clk);
    waited = 0;
    while (due_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
    if (due_q.size() != 0) begin
      $display("%0d expected result items never arrived", due_q.size());
      errors += due_q.size();
    end
    $display("sent %0d bytes and ticks over eight register settings", fed);
    $display("checked %0d results: %0d packets, %0d bad checksums, %0d link drops, %0d errors",
             results_seen, delivered, bad_sums, drops, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/fpdh_pkg.sv
rtl/core/fpdh_item_if.sv
rtl/core/fpdh_result_if.sv
rtl/core/fpdh_cfg_if.sv
rtl/core/framed_packet_deframer_heartbeat.sv
tb/sv/testbench.sv
